>>> rtl/fwcfg_pkg.sv
// Shared types and constants for the firmware configuration port.
package fwcfg_pkg;
   localparam int MaxFiles = 16;
   localparam int FileBytes = 4096;
   localparam int NameBytes = 56;
   localparam int SlotW = 4;
   localparam int PosW = 12;
   localparam int FbAddrW = SlotW + PosW;
   localparam int NameAddrW = 10;
   localparam int SizeW = 13;
   localparam int CountW = 5;

   localparam logic [15:0] FirstFileSel = 16'h0020;
   localparam logic [15:0] DirSel = 16'h0019;
   localparam logic [7:0] Nothing = 8'hFF;

   // Built-in item selectors
   localparam logic [15:0] SelSignature = 16'h0000;
   localparam logic [15:0] SelVersion = 16'h0001;
   localparam logic [15:0] SelUuid = 16'h0002;
   localparam logic [15:0] SelRam = 16'h0003;
   localparam logic [15:0] SelNoGfx = 16'h0004;
   localparam logic [15:0] SelCpu = 16'h0005;
   localparam logic [15:0] SelMachine = 16'h0006;
   localparam logic [15:0] SelMaxCpu = 16'h000F;

   typedef enum logic [2:0] {
      ACT_SELECT = 3'd0,
      ACT_READ = 3'd1,
      ACT_WRITE = 3'd2,
      ACT_ADD = 3'd3,
      ACT_LOAD_BYTE = 3'd4,
      ACT_LOAD_NAME = 3'd5,
      ACT_RSV6 = 3'd6,
      ACT_RSV7 = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      CSR_RAM = 3'd0,
      CSR_CPU = 3'd1,
      CSR_MAXCPU = 3'd2,
      CSR_NOGFX = 3'd3,
      CSR_MACHINE = 3'd4,
      CSR_UUID_HI = 3'd5,
      CSR_UUID_LO = 3'd6,
      CSR_RSV7 = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      SRC_CONST,
      SRC_FILE,
      SRC_NAME
   } src_type;

   // Memory request (lookup read or byte/name write), issued in the accept cycle, read data in the next cycle
   typedef struct packed {
      logic [FbAddrW-1:0] fb_addr;
      logic [NameAddrW-1:0] name_addr;
      logic wr_byte;
      logic wr_name;
      logic [7:0] wdata;
   } mem_req_type;
endpackage

>>> rtl/firmware_config_item_port.sv
// Top level of the firmware configuration item port.
// A data read beat gives its byte on rsp_ in the cycle after its accepting edge.
// Busy is high in the cycle after each accept, so no new beat is taken while the
// byte memories are still being read for the last one.
// Reset clears selector, offset and file count, restores config register defaults;
// name memory is cleared by a sweep of its 896 bytes after reset while busy stays high.
module firmware_config_item_port
   import fwcfg_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input logic [2:0] req_action,
   input logic [15:0] req_value,
   input logic [3:0] req_file_slot,
   input logic [11:0] req_byte_position,
   output logic rsp_valid,
   output logic [7:0] rsp_read_data,
   input logic csr_write,
   input logic [2:0] csr_index,
   input logic [63:0] csr_wdata
);
   logic [63:0] ram_ff, uuid_hi_ff, uuid_lo_ff;
   logic [15:0] cpu_ff, maxcpu_ff, nogfx_ff, machine_ff;
   logic [15:0] sel_ff, sel_in;
   logic [31:0] off_ff, off_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [SizeW-1:0] sizes_ff [MaxFiles];
   logic clr_ff, clr_in;
   logic [NameAddrW-1:0] clr_addr_ff, clr_addr_in;
   logic pend_ff, pend_in;
   logic rd_ff, rd_in;
   src_type src_ff, src_in;
   logic [7:0] const_ff, const_in;
   logic [7:0] fb_rdata, name_rdata;
   mem_req_type mreq;
   logic accept;
   action_type act;

   assign act = action_type'(req_action);
   assign busy = clr_ff | pend_ff;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_ff <= '0; cpu_ff <= 16'd1; maxcpu_ff <= 16'd1; nogfx_ff <= '0;
         machine_ff <= 16'd1; uuid_hi_ff <= '0; uuid_lo_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_RAM: ram_ff <= csr_wdata;
            CSR_CPU: cpu_ff <= csr_wdata[15:0];
            CSR_MAXCPU: maxcpu_ff <= csr_wdata[15:0];
            CSR_NOGFX: nogfx_ff <= csr_wdata[15:0];
            CSR_MACHINE: machine_ff <= csr_wdata[15:0];
            CSR_UUID_HI: uuid_hi_ff <= csr_wdata;
            CSR_UUID_LO: uuid_lo_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Byte lookup for the current selector/offset
   logic [31:0] dir_rel;
   logic [25:0] dir_slot_w;
   logic [SlotW-1:0] dir_slot;
   logic [5:0] dir_k;
   logic [SlotW-1:0] fslot;
   logic [15:0] fsel_rel;
   logic [15:0] dsel;
   logic [SizeW-1:0] dsize;
   logic [31:0] dsize32, dcount32, dir_len;
   logic [6:0] sh;

   assign dir_rel = off_ff - 32'd4;
   assign dir_slot_w = dir_rel[31:6];
   assign dir_slot = dir_slot_w[SlotW-1:0];
   assign dir_k = dir_rel[5:0];
   assign fsel_rel = sel_ff - FirstFileSel;
   assign fslot = fsel_rel[SlotW-1:0];
   assign dsel = FirstFileSel + {12'd0, dir_slot};
   assign dsize = sizes_ff[dir_slot];
   assign dsize32 = {{(32-SizeW){1'b0}}, dsize};
   assign dcount32 = {{(32-CountW){1'b0}}, count_ff};
   assign dir_len = 32'd4 + {dcount32[25:0], 6'd0};

   always_comb begin
      src_in = SRC_CONST;
      const_in = Nothing;
      sh = '0;
      if (sel_ff >= FirstFileSel) begin
         if ({16'd0, fsel_rel} < dcount32 &&
             off_ff < {{(32-SizeW){1'b0}}, sizes_ff[fslot]}) begin
            src_in = SRC_FILE;
         end
      end else begin
         unique case (sel_ff)
            SelSignature: if (off_ff < 32'd4) begin
               unique case (off_ff[1:0])
                  2'd0: const_in = 8'h51;
                  2'd1: const_in = 8'h45;
                  2'd2: const_in = 8'h4D;
                  default: const_in = 8'h55;
               endcase
            end
            SelVersion: if (off_ff < 32'd4) const_in = (off_ff[1:0] == 2'd0) ? 8'd3 : 8'd0;
            SelUuid: if (off_ff < 32'd8) begin
               sh = {1'b0, (3'd7 - off_ff[2:0]), 3'd0};
               const_in = 8'(uuid_hi_ff >> sh);
            end else if (off_ff < 32'd16) begin
               sh = {1'b0, (3'd7 - off_ff[2:0]), 3'd0};
               const_in = 8'(uuid_lo_ff >> sh);
            end
            SelRam: if (off_ff < 32'd8) begin
               sh = {1'b0, off_ff[2:0], 3'd0};
               const_in = 8'(ram_ff >> sh);
            end
            SelNoGfx: if (off_ff < 32'd2) const_in = off_ff[0] ? nogfx_ff[15:8] : nogfx_ff[7:0];
            SelCpu: if (off_ff < 32'd2) const_in = off_ff[0] ? cpu_ff[15:8] : cpu_ff[7:0];
            SelMachine: if (off_ff < 32'd2)
               const_in = off_ff[0] ? machine_ff[15:8] : machine_ff[7:0];
            SelMaxCpu: if (off_ff < 32'd2)
               const_in = off_ff[0] ? maxcpu_ff[15:8] : maxcpu_ff[7:0];
            DirSel: if (off_ff < dir_len) begin
               if (off_ff < 32'd4) begin
                  sh = {2'd0, (2'd3 - off_ff[1:0]), 3'd0};
                  const_in = 8'(dcount32 >> sh);
               end else if (dir_k < 6'd4) begin
                  sh = {2'd0, (2'd3 - dir_k[1:0]), 3'd0};
                  const_in = 8'(dsize32 >> sh);
               end else if (dir_k == 6'd4) begin
                  const_in = dsel[15:8];
               end else if (dir_k == 6'd5) begin
                  const_in = dsel[7:0];
               end else if (dir_k < 6'd8 || dir_k == 6'd63) begin
                  const_in = 8'd0;
               end else begin
                  src_in = SRC_NAME;
               end
            end
            default: ;
         endcase
      end
   end

   // Memory port: sweep, load, or read lookup
   always_comb begin
      mreq.wr_byte = 1'b0;
      mreq.wr_name = 1'b0;
      mreq.wdata = req_value[7:0];
      mreq.fb_addr = (sel_ff >= FirstFileSel) ? {fslot, off_ff[PosW-1:0]} : '0;
      mreq.name_addr = NameAddrW'({6'd0, dir_slot} * NameBytes + ({4'd0, dir_k} - 10'd8));
      if (clr_ff) begin
         mreq.wr_name = 1'b1;
         mreq.wdata = 8'd0;
         mreq.name_addr = clr_addr_ff;
      end else if (accept && act == ACT_LOAD_BYTE) begin
         mreq.wr_byte = 1'b1;
         mreq.fb_addr = {req_file_slot, req_byte_position};
      end else if (accept && act == ACT_LOAD_NAME) begin
         mreq.wr_name = req_byte_position < 12'(NameBytes);
         mreq.name_addr = NameAddrW'({6'd0, req_file_slot} * NameBytes +
                                     {4'd0, req_byte_position[5:0]});
      end
   end

   fwcfg_mem u_mem (
      .clock(clock), .req(mreq), .fb_rdata(fb_rdata), .name_rdata(name_rdata)
   );

   always_comb begin
      sel_in = sel_ff;
      off_in = off_ff;
      count_in = count_ff;
      rd_in = 1'b0;
      pend_in = accept;
      clr_in = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == NameAddrW'(MaxFiles*NameBytes - 1)) clr_in = 1'b0;
      end
      if (accept) begin
         unique case (act)
            ACT_SELECT: begin
               sel_in = req_value;
               off_in = '0;
            end
            ACT_READ: begin
               rd_in = 1'b1;
               off_in = off_ff + 32'd1;
            end
            ACT_WRITE: off_in = off_ff + 32'd1;
            ACT_ADD: if (count_ff < CountW'(MaxFiles)) count_in = count_ff + 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept && act == ACT_ADD && count_ff < CountW'(MaxFiles)) begin
         sizes_ff[count_ff[SlotW-1:0]] <= (req_value > 16'(FileBytes)) ?
            SizeW'(FileBytes) : req_value[SizeW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= '0; off_ff <= '0; count_ff <= '0;
         pend_ff <= 1'b0; rd_ff <= 1'b0;
         clr_ff <= 1'b1; clr_addr_ff <= '0;
      end else begin
         sel_ff <= sel_in; off_ff <= off_in; count_ff <= count_in;
         pend_ff <= pend_in; rd_ff <= rd_in;
         clr_ff <= clr_in; clr_addr_ff <= clr_addr_in;
      end
      src_ff <= src_in;
      const_ff <= const_in;
   end

   assign rsp_valid = rd_ff;
   always_comb begin
      unique case (src_ff)
         SRC_FILE: rsp_read_data = fb_rdata;
         SRC_NAME: rsp_read_data = name_rdata;
         default: rsp_read_data = const_ff;
      endcase
   end

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !accept) else $error("accept during name clear");
   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept)) else $error("response without request");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("no interlock after accept");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(MaxFiles)) else $error("file count overflow");
endmodule

>>> rtl/fwcfg_mem.sv
// File data and file name byte memories with registered read data.
module fwcfg_mem
   import fwcfg_pkg::*;
(
   input logic clock,
   input mem_req_type req,
   output logic [7:0] fb_rdata,
   output logic [7:0] name_rdata
);
   logic [7:0] fb_mem [MaxFiles*FileBytes];
   logic [7:0] name_mem [MaxFiles*NameBytes];

   always_ff @(posedge clock) begin
      if (req.wr_byte) begin
         fb_mem[req.fb_addr] <= req.wdata;
      end
      fb_rdata <= fb_mem[req.fb_addr];
   end

   always_ff @(posedge clock) begin
      if (req.wr_name) begin
         name_mem[req.name_addr] <= req.wdata;
      end
      name_rdata <= name_mem[req.name_addr];
   end
endmodule

>>> dv/firmware_config_item_port_tb.sv
// Self-checking testbench for the firmware configuration item port.
module firmware_config_item_port_tb;
   import fwcfg_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit = 20000;
   localparam int ItemsPerPhase = 212;

   class fwcfg_scoreboard;
      logic [63:0] ram, uuid_hi, uuid_lo;
      logic [15:0] cpu, maxcpu, nogfx, machine;
      logic [15:0] sel;
      logic [31:0] offset;
      int count;
      int sizes[MaxFiles];
      logic [7:0] fdata[MaxFiles*FileBytes];
      bit loaded[MaxFiles*FileBytes];
      logic [7:0] names[MaxFiles*NameBytes];
      logic [7:0] read_q[$];
      int errors;

      function new();
         ram = 0; cpu = 1; maxcpu = 1; nogfx = 0; machine = 1; uuid_hi = 0; uuid_lo = 0;
         sel = 0; offset = 0; count = 0; errors = 0;
         foreach (sizes[i]) sizes[i] = 0;
         foreach (names[i]) names[i] = 8'h00;
      endfunction

      function void set_reg(csr_index_type idx, logic [63:0] v);
         case (idx)
            CSR_RAM: ram = v;
            CSR_CPU: cpu = v[15:0];
            CSR_MAXCPU: maxcpu = v[15:0];
            CSR_NOGFX: nogfx = v[15:0];
            CSR_MACHINE: machine = v[15:0];
            CSR_UUID_HI: uuid_hi = v;
            CSR_UUID_LO: uuid_lo = v;
            default: ;
         endcase
      endfunction

      function logic [7:0] le_byte(logic [63:0] v, logic [31:0] off, int len);
         if (off >= len) return Nothing;
         return 8'(v >> (off * 8));
      endfunction

      function logic [7:0] be32(logic [31:0] v, int k);
         return 8'(v >> ((3 - k) * 8));
      endfunction

      function logic [7:0] dir_byte(logic [31:0] off);
         int rel, slot, k;
         logic [15:0] fsel;
         if (off >= 4 + count * 64) return Nothing;
         if (off < 4) return be32(count, off);
         rel = off - 4;
         slot = rel / 64;
         k = rel % 64;
         fsel = 16'(FirstFileSel + slot);
         if (k < 4) return be32(sizes[slot], k);
         if (k == 4) return fsel[15:8];
         if (k == 5) return fsel[7:0];
         if (k < 8) return 8'h00;
         k -= 8;
         if (k >= NameBytes - 1) return 8'h00;
         return names[slot*NameBytes + k];
      endfunction

      function logic [7:0] item_byte();
         int slot;
         if (sel >= FirstFileSel) begin
            slot = sel - FirstFileSel;
            if (slot >= count || offset >= sizes[slot]) return Nothing;
            return fdata[slot*FileBytes + offset];
         end
         case (sel)
            SelSignature: return offset < 4 ? 8'(32'h554D4551 >> (offset*8)) : Nothing;
            SelVersion: return le_byte(64'd3, offset, 4);
            SelUuid: begin
               if (offset < 8) return 8'(uuid_hi >> ((7 - offset) * 8));
               if (offset < 16) return 8'(uuid_lo >> ((15 - offset) * 8));
               return Nothing;
            end
            SelRam: return le_byte(ram, offset, 8);
            SelNoGfx: return le_byte(nogfx, offset, 2);
            SelCpu: return le_byte(cpu, offset, 2);
            SelMachine: return le_byte(machine, offset, 2);
            SelMaxCpu: return le_byte(maxcpu, offset, 2);
            DirSel: return dir_byte(offset);
            default: return Nothing;
         endcase
      endfunction

      // a read here would hit a file byte never loaded
      function bit hits_unloaded();
         int slot;
         if (sel < FirstFileSel) return 0;
         slot = sel - FirstFileSel;
         if (slot >= count || offset >= sizes[slot]) return 0;
         return !loaded[slot*FileBytes + offset];
      endfunction

      function void note_beat(action_type act, logic [15:0] v, logic [3:0] s, logic [11:0] p);
         case (act)
            ACT_SELECT: begin sel = v; offset = 0; end
            ACT_READ: begin read_q = {read_q, item_byte()}; offset++; end
            ACT_WRITE: offset++;
            ACT_ADD: if (count < MaxFiles) begin
               sizes[count] = v > FileBytes ? FileBytes : v;
               count++;
            end
            ACT_LOAD_BYTE: begin
               fdata[s*FileBytes + p] = v[7:0];
               loaded[s*FileBytes + p] = 1;
            end
            ACT_LOAD_NAME: if (p < NameBytes) names[s*NameBytes + p] = v[7:0];
            default: ;
         endcase
      endfunction

      function void check_byte(logic [7:0] got);
         logic [7:0] want;
         if (read_q.size() == 0) begin
            $display("%0t: unexpected read byte %02h", $time, got);
            errors++;
            return;
         end
         want = read_q.pop_front();
         if (got !== want) begin
            $display("%0t: read_data expected %02h actual %02h", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1, start = 0, csr_write = 0;
   logic busy, rsp_valid;
   logic [2:0] req_action = 0, csr_index = 0;
   logic [15:0] req_value = 0;
   logic [3:0] req_file_slot = 0;
   logic [11:0] req_byte_position = 0;
   logic [63:0] csr_wdata = 0;
   logic [7:0] rsp_read_data;

   fwcfg_scoreboard sb = new();
   int idle_pct = 0;
   int sent = 0;
   int quiet = 0;

   firmware_config_item_port dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_byte(rsp_read_data);
      if ((start && !busy) || rsp_valid) quiet = 0;
      else quiet++;
      if (quiet >= IdleLimit) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic push_beat(action_type act, logic [15:0] v, logic [3:0] s, logic [11:0] p);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock) start = 0;
      end
      @(negedge clock);
      start = 1; req_action = act; req_value = v; req_file_slot = s; req_byte_position = p;
      do @(posedge clock); while (busy);
      sb.note_beat(act, v, s, p);
      sent++;
   endtask

   // reads never land on an unloaded file byte: load it first
   task automatic read_beat();
      if (sb.hits_unloaded())
         push_beat(ACT_LOAD_BYTE, 16'($urandom), 4'(sb.sel - FirstFileSel), 12'(sb.offset));
      push_beat(ACT_READ, 16'($urandom), 4'($urandom), 12'($urandom));
   endtask

   task automatic write_regs(int mode);
      logic [63:0] v;
      @(negedge clock) start = 0;
      while (sb.read_q.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
      for (int i = CSR_RAM; i <= CSR_UUID_LO; i++) begin
         v = mode == 0 ? 64'd0 : mode == 1 ? '1 : {$urandom, $urandom};
         @(negedge clock);
         csr_write = 1; csr_index = 3'(i); csr_wdata = v;
         sb.set_reg(csr_index_type'(i), v);
      end
      @(negedge clock) csr_write = 0;
   endtask

   function automatic logic [15:0] pick_selector();
      case ($urandom_range(11))
         0: return SelSignature;
         1: return SelVersion;
         2: return SelUuid;
         3: return SelRam;
         4: return SelNoGfx;
         5: return SelCpu;
         6: return SelMachine;
         7: return SelMaxCpu;
         8, 9: return DirSel;
         10: return 16'(FirstFileSel + $urandom_range(17));
         default: return $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(7, 31));
      endcase
   endfunction

   task automatic random_sequence();
      int n;
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            push_beat(ACT_SELECT, pick_selector(), 4'($urandom), 12'($urandom));
            if ($urandom_range(3) == 0) begin
               n = $urandom_range(300);
               repeat (n) push_beat(ACT_WRITE, 16'($urandom), 4'($urandom), 12'($urandom));
            end
            repeat ($urandom_range(1, 20)) begin
               if ($urandom_range(9) == 0)
                  push_beat(ACT_WRITE, 16'($urandom), 4'($urandom), 12'($urandom));
               else read_beat();
            end
         end
         4: push_beat(ACT_ADD, $urandom_range(3) ? 16'($urandom_range(40)) : 16'($urandom),
                      4'($urandom), 12'($urandom));
         5, 6: begin
            n = $urandom_range(15);
            repeat ($urandom_range(1, 12))
               push_beat(ACT_LOAD_BYTE, 16'($urandom), 4'(n),
                         $urandom_range(1) ? 12'($urandom_range(40)) : 12'($urandom));
         end
         7, 8:
            repeat ($urandom_range(1, 8))
               push_beat(ACT_LOAD_NAME, 16'($urandom), 4'($urandom), 12'($urandom_range(63)));
         default: begin
            n = $urandom_range(7);
            if (n == ACT_READ) read_beat();
            else push_beat(action_type'(n), 16'($urandom), 4'($urandom), 12'($urandom));
         end
      endcase
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset = 0;
      // directed: reset values, past-the-end reads, clamping, ignored loads
      push_beat(ACT_SELECT, SelSignature, 4'd0, 12'd0);
      repeat (5) read_beat();
      push_beat(ACT_WRITE, 16'hFFFF, 4'hF, 12'hFFF);
      push_beat(ACT_SELECT, SelMaxCpu, 4'hF, 12'hFFF);
      repeat (3) read_beat();
      push_beat(ACT_ADD, 16'd5000, 4'd0, 12'd0);
      push_beat(ACT_ADD, 16'd0, 4'd0, 12'd0);
      push_beat(ACT_LOAD_NAME, 16'h00AB, 4'd0, 12'd0);
      push_beat(ACT_LOAD_NAME, 16'hFF5A, 4'd0, 12'd55);
      push_beat(ACT_LOAD_NAME, 16'h0077, 4'd0, 12'd56);
      push_beat(ACT_LOAD_BYTE, 16'hFFC3, 4'hF, 12'hFFF);
      push_beat(ACT_RSV6, 16'hFFFF, 4'hF, 12'hFFF);
      push_beat(ACT_RSV7, 16'h0000, 4'h0, 12'h000);
      push_beat(ACT_SELECT, DirSel, 4'd0, 12'd0);
      repeat (5) read_beat();
      push_beat(ACT_SELECT, FirstFileSel, 4'd0, 12'd0);
      read_beat();
      push_beat(ACT_SELECT, 16'hFFFF, 4'd0, 12'd0);
      read_beat();
      for (int ph = 0; ph < 4; ph++) begin
         write_regs(ph);
         idle_pct = ph == 1 ? 63 : ph == 3 ? 7 : 0;
         while (sent < (ph + 1) * ItemsPerPhase + 30) random_sequence();
      end
      @(negedge clock) start = 0;
      while (sb.read_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end
endmodule
